// ----- sv/canonical_decimal_int32_check_assert.svh -----
// assertion macros used by the checker file cdi32_checker.sv
// no dependencies; include by bare file name
`ifndef CANONICAL_DECIMAL_INT32_CHECK_ASSERT_SVH
`define CANONICAL_DECIMAL_INT32_CHECK_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CDI32_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cdi32 assertion failed");

// next-cycle implication, disabled during reset
`define CDI32_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cdi32 assertion failed");

`endif

// ----- sv/cdi32_pkg.sv -----
// types and constants of the canonical decimal int32 checker
// no dependencies
`timescale 1ns / 1ps

package cdi32_pkg;

	// character codes
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// magnitude limits and digit limit
	localparam logic [31:0] POS_LIMIT  = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_LIMIT  = 32'h8000_0000;
	localparam logic [3:0]  MAX_DIGITS = 4'd10;
	localparam logic [3:0]  COUNT_SAT  = 4'd15;

	// parse phase
	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_MINUS  = 3'd1,
		PH_DIGITS = 3'd2,
		PH_ZERO   = 3'd3
	} phase_t;

	// input transaction
	typedef struct packed {
		logic [7:0] char_byte;
		logic       has_char;
		logic       end_of_string;
	} in_item_t;

	// result transaction
	typedef struct packed {
		logic               is_valid;
		logic signed [31:0] parsed_value;
	} out_item_t;

	// parser state
	typedef struct packed {
		phase_t      phase;
		logic        negative_seen;
		logic [31:0] magnitude_acc;
		logic [3:0]  digit_count;
		logic        error_seen;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:         PH_START,
		negative_seen: 1'b0,
		magnitude_acc: 32'd0,
		digit_count:   4'd0,
		error_seen:    1'b0
	};

endpackage

// ----- sv/cdi32_parse_core.sv -----
// parser state register and per-character step logic
// depends on cdi32_pkg
`timescale 1ns / 1ps

module cdi32_parse_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  cdi32_pkg::in_item_t  item,
	output cdi32_pkg::out_item_t result
);

	cdi32_pkg::parse_state_t state_q;
	cdi32_pkg::parse_state_t add_state;
	cdi32_pkg::parse_state_t nxt;

	logic [7:0]  char_diff;
	logic [3:0]  digit;
	logic        is_digit;
	logic        is_minus;
	logic [35:0] mag10;
	logic [3:0]  cnt_inc;
	logic        ok;
	logic [31:0] val;

	// character classification
	assign is_minus  = (item.char_byte == cdi32_pkg::CHAR_MINUS);
	assign is_digit  = (item.char_byte >= cdi32_pkg::CHAR_ZERO) &&
		(item.char_byte <= cdi32_pkg::CHAR_NINE);
	assign char_diff = item.char_byte - cdi32_pkg::CHAR_ZERO;
	assign digit     = char_diff[3:0];

	// times ten plus digit, with saturating digit count
	assign mag10 = {1'b0, state_q.magnitude_acc, 3'b000} +
		{3'b000, state_q.magnitude_acc, 1'b0} + {32'd0, digit};
	assign cnt_inc = (state_q.digit_count == cdi32_pkg::COUNT_SAT) ?
		state_q.digit_count : state_q.digit_count + 4'd1;

	// state after appending one digit
	always_comb begin
		add_state = state_q;
		add_state.digit_count = cnt_inc;
		if (cnt_inc > cdi32_pkg::MAX_DIGITS || mag10 > {4'd0, cdi32_pkg::NEG_LIMIT}) begin
			add_state.error_seen = 1'b1;
		end else begin
			add_state.magnitude_acc = mag10[31:0];
		end
	end

	// next state for the current character
	always_comb begin
		nxt = state_q;
		if (item.has_char && !state_q.error_seen) begin
			case (state_q.phase)
				cdi32_pkg::PH_START: begin
					if (is_minus) begin
						nxt.negative_seen = 1'b1;
						nxt.phase = cdi32_pkg::PH_MINUS;
					end else if (is_digit && digit == 4'd0) begin
						nxt.digit_count = 4'd1;
						nxt.phase = cdi32_pkg::PH_ZERO;
					end else if (is_digit) begin
						nxt = add_state;
						nxt.phase = cdi32_pkg::PH_DIGITS;
					end else begin
						nxt.error_seen = 1'b1;
					end
				end
				cdi32_pkg::PH_MINUS: begin
					if (is_digit && digit != 4'd0) begin
						nxt = add_state;
						nxt.phase = cdi32_pkg::PH_DIGITS;
					end else begin
						nxt.error_seen = 1'b1;
					end
				end
				cdi32_pkg::PH_DIGITS: begin
					if (is_digit) begin
						nxt = add_state;
					end else begin
						nxt.error_seen = 1'b1;
					end
				end
				default: begin
					// lone leading zero takes no further character
					nxt.error_seen = 1'b1;
				end
			endcase
		end
	end

	// verdict and signed value from the updated state
	always_comb begin
		ok  = !nxt.error_seen &&
			(nxt.phase == cdi32_pkg::PH_DIGITS || nxt.phase == cdi32_pkg::PH_ZERO);
		val = 32'd0;
		if (ok) begin
			if (nxt.negative_seen) begin
				if (nxt.magnitude_acc > cdi32_pkg::NEG_LIMIT) begin
					ok = 1'b0;
				end else begin
					val = 32'd0 - nxt.magnitude_acc;
				end
			end else begin
				if (nxt.magnitude_acc > cdi32_pkg::POS_LIMIT) begin
					ok = 1'b0;
				end else begin
					val = nxt.magnitude_acc;
				end
			end
		end
		result.is_valid     = ok;
		result.parsed_value = $signed(val);
	end

	// state register, cleared after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdi32_pkg::STATE_RESET;
		end else if (step_en) begin
			state_q <= item.end_of_string ? cdi32_pkg::STATE_RESET : nxt;
		end
	end

endmodule

// ----- sv/canonical_decimal_int32_check.sv -----
// top level of the canonical decimal int32 checker
// depends on cdi32_pkg and cdi32_parse_core
`timescale 1ns / 1ps

// Takes a string one byte per transaction and, on the transaction marked
// end_of_string, returns one result: whether the string is the canonical
// decimal form of a signed 32-bit integer (optional '-', no leading zero,
// no "-0", in range) and its value, or 0 when not valid. One character is
// accepted every cycle while input is not stalled; the result is offered in
// the cycle after its end transaction leaves the input register, which it
// does once the result register is free. The parse state register steps
// once per character, fed from an input register, with a result register on
// the output side so input keeps flowing while a result waits. Input stalls
// only while an end transaction sits in the input register behind a result
// that is not being taken.

module canonical_decimal_int32_check (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_ready,
	input  cdi32_pkg::in_item_t  char_data,
	output logic                 res_valid,
	input  logic                 res_ready,
	output cdi32_pkg::out_item_t res_data
);

	logic                 valid_s1;
	cdi32_pkg::in_item_t  item_s1;
	logic                 res_valid_q;
	cdi32_pkg::out_item_t res_data_q;
	cdi32_pkg::out_item_t core_result;
	logic                 out_free;
	logic                 s1_go;

	// stage advance: end transactions need room in the result register
	assign out_free   = !res_valid_q || res_ready;
	assign s1_go      = valid_s1 && (!item_s1.end_of_string || out_free);
	assign char_ready = !valid_s1 || s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			item_s1 <= char_data;
		end
	end

	cdi32_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (s1_go),
		.item    (item_s1),
		.result  (core_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && item_s1.end_of_string) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.end_of_string) begin
			res_data_q <= core_result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

// ----- sv/cdi32_checker.sv -----
// port-level assertions for the canonical decimal int32 checker
// depends on cdi32_pkg and canonical_decimal_int32_check_assert.svh
`timescale 1ns / 1ps
`include "canonical_decimal_int32_check_assert.svh"

module cdi32_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 char_valid,
	input logic                 char_ready,
	input cdi32_pkg::in_item_t  char_data,
	input logic                 res_valid,
	input logic                 res_ready,
	input cdi32_pkg::out_item_t res_data
);

	// an invalid verdict always carries a zero value
	`CDI32_ASSERT_IMPLY(a_invalid_zero, clk, arst_n, res_valid && !res_data.is_valid, res_data.parsed_value == 32'sd0)

	// input stalls only behind a result that is not being taken
	`CDI32_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !char_ready, res_valid && !res_ready)

	// a pending result transaction stays offered
	`CDI32_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)

	// a pending result transaction keeps its payload
	`CDI32_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_data))

endmodule

bind canonical_decimal_int32_check cdi32_checker u_cdi32_checker (.*);

// ----- sim/canonical_decimal_int32_check_tb.sv -----
`timescale 1ns / 1ps
// testbench for canonical_decimal_int32_check: directed and random strings, checked
// against a behavioral parser kept in this file; depends on cdi32_pkg and the rtl

module canonical_decimal_int32_check_tb;

	localparam int ITEM_TARGET = 1300;
	localparam int DRAIN_AT    = 900;
	localparam int HOLD_START  = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_HIGH  = 8'hFF;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 char_valid = 1'b0;
	logic                 char_ready;
	cdi32_pkg::in_item_t  char_data = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	cdi32_pkg::out_item_t res_data;

	cdi32_pkg::in_item_t  pending_chars[$];
	bit                   pending_drain[$];
	cdi32_pkg::out_item_t expected_results[$];
	logic [7:0]           str_buf[$];
	bit                   drain_mark = 1'b0;
	bit                   drain_placed = 1'b0;
	bit                   char_taken = 1'b0;
	int                   fail_count = 0;
	int                   burst_left = 0;
	int                   gap_left = 0;
	int                   rx_cycle = 0;

	canonical_decimal_int32_check u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// parser state of the predictor
	cdi32_pkg::phase_t ps_phase;
	logic              ps_neg;
	logic [31:0]       ps_mag;
	logic [3:0]        ps_count;
	logic              ps_err;

	function automatic void clear_parse();
		ps_phase = cdi32_pkg::PH_START;
		ps_neg   = 1'b0;
		ps_mag   = '0;
		ps_count = '0;
		ps_err   = 1'b0;
	endfunction

	// accumulate one digit, flag overflow or too many digits
	function automatic void push_digit(logic [3:0] d);
		logic [63:0] next;
		next = {32'd0, ps_mag} * 64'd10 + {60'd0, d};
		if (ps_count != cdi32_pkg::COUNT_SAT)
			ps_count = ps_count + 4'd1;
		if (ps_count > cdi32_pkg::MAX_DIGITS || next > {32'd0, cdi32_pkg::NEG_LIMIT})
			ps_err = 1'b1;
		else
			ps_mag = next[31:0];
	endfunction

	function automatic void absorb_char(logic [7:0] c);
		logic       is_dig;
		logic [3:0] d;
		is_dig = (c >= cdi32_pkg::CHAR_ZERO) && (c <= cdi32_pkg::CHAR_NINE);
		d = is_dig ? 4'(c - cdi32_pkg::CHAR_ZERO) : 4'd0;
		if (!ps_err) begin
			case (ps_phase)
				cdi32_pkg::PH_START: begin
					if (c == cdi32_pkg::CHAR_MINUS) begin
						ps_neg = 1'b1;
						ps_phase = cdi32_pkg::PH_MINUS;
					end else if (is_dig && d == 4'd0) begin
						ps_count = 4'd1;
						ps_phase = cdi32_pkg::PH_ZERO;
					end else if (is_dig) begin
						push_digit(d);
						ps_phase = cdi32_pkg::PH_DIGITS;
					end else begin
						ps_err = 1'b1;
					end
				end
				cdi32_pkg::PH_MINUS: begin
					if (is_dig && d != 4'd0) begin
						push_digit(d);
						ps_phase = cdi32_pkg::PH_DIGITS;
					end else begin
						ps_err = 1'b1;
					end
				end
				cdi32_pkg::PH_DIGITS: begin
					if (is_dig)
						push_digit(d);
					else
						ps_err = 1'b1;
				end
				default: ps_err = 1'b1;
			endcase
		end
	endfunction

	// end of string: form the verdict and value, then start over
	function automatic void close_string();
		cdi32_pkg::out_item_t r;
		logic                 ok;
		ok = !ps_err && (ps_phase == cdi32_pkg::PH_DIGITS || ps_phase == cdi32_pkg::PH_ZERO);
		r.parsed_value = '0;
		if (ok) begin
			if (ps_neg) begin
				if (ps_mag > cdi32_pkg::NEG_LIMIT)
					ok = 1'b0;
				else
					r.parsed_value = 32'd0 - ps_mag;
			end else begin
				if (ps_mag > cdi32_pkg::POS_LIMIT)
					ok = 1'b0;
				else
					r.parsed_value = ps_mag;
			end
		end
		if (!ok)
			r.parsed_value = '0;
		r.is_valid = ok;
		expected_results.push_back(r);
		clear_parse();
	endfunction

	function automatic void predict_item(cdi32_pkg::in_item_t it);
		if (it.has_char)
			absorb_char(it.char_byte);
		if (it.end_of_string)
			close_string();
	endfunction

	// stimulus helpers
	function automatic void push_item(logic [7:0] c, logic has, logic eos);
		cdi32_pkg::in_item_t it;
		it.char_byte = c;
		it.has_char = has;
		it.end_of_string = eos;
		pending_chars.push_back(it);
		pending_drain.push_back(drain_mark);
		drain_mark = 1'b0;
	endfunction

	// the end flag rides on the last character or on a bare end transaction
	function automatic void send_string(bit bare_end, bit with_noise);
		int n;
		n = str_buf.size();
		for (int i = 0; i < n; i++) begin
			if (with_noise && $urandom_range(0, 9) == 0)
				push_item(8'($urandom), 1'b0, 1'b0);
			push_item(str_buf[i], 1'b1, (i == n - 1) && !bare_end);
		end
		if (bare_end || n == 0)
			push_item(8'($urandom), 1'b0, 1'b1);
	endfunction

	function automatic void load_text(string s);
		str_buf.delete();
		for (int i = 0; i < s.len(); i++)
			str_buf.push_back(s[i]);
	endfunction

	function automatic logic [7:0] noise_byte();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 10)
			return cdi32_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
		else if (pick < 12)
			return cdi32_pkg::CHAR_MINUS;
		else if (pick < 14)
			return CHAR_PLUS;
		else if (pick == 14)
			return CHAR_SPACE;
		else if (pick == 15)
			return CHAR_NUL;
		return 8'($urandom);
	endfunction

	// well-formed decimal text with a bias toward the int32 edges
	function automatic void load_number();
		longint v;
		int     len;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, 9);
			1: v = $urandom_range(0, 99999);
			2: begin
				v = $urandom_range(1, 99999);
				v = -v;
			end
			3: v = longint'($urandom);
			4: v = -longint'($urandom);
			5: begin
				case ($urandom_range(0, 9))
					0: v = 64'sd2147483647;
					1: v = -64'sd2147483648;
					2: v = 64'sd2147483648;
					3: v = -64'sd2147483649;
					4: v = 64'sd2147483646;
					5: v = -64'sd2147483647;
					6: v = 64'sd4294967295;
					7: v = 64'sd9999999999;
					8: v = -64'sd9999999999;
					default: v = 64'sd1000000000;
				endcase
			end
			6: begin
				// eleven or more digits, past the digit limit
				str_buf.delete();
				if ($urandom_range(0, 1))
					str_buf.push_back(cdi32_pkg::CHAR_MINUS);
				len = $urandom_range(11, 17);
				str_buf.push_back(cdi32_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)));
				for (int k = 1; k < len; k++)
					str_buf.push_back(cdi32_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
				return;
			end
			default: v = longint'(int'($urandom));
		endcase
		load_text($sformatf("%0d", v));
	endfunction

	// change a well-formed number in one place, which can break it
	function automatic void mutate();
		int pos;
		case ($urandom_range(0, 5))
			0: str_buf.push_front(cdi32_pkg::CHAR_ZERO);
			1: str_buf.push_front(CHAR_PLUS);
			2: str_buf.push_front(cdi32_pkg::CHAR_MINUS);
			3: str_buf.push_back(CHAR_SPACE);
			4: begin
				pos = $urandom_range(0, str_buf.size() - 1);
				str_buf[pos] = noise_byte();
			end
			default: begin
				if (str_buf[0] == cdi32_pkg::CHAR_MINUS)
					str_buf.insert(1, cdi32_pkg::CHAR_ZERO);
				else begin
					str_buf.push_front(cdi32_pkg::CHAR_ZERO);
					str_buf.push_front(cdi32_pkg::CHAR_MINUS);
				end
			end
		endcase
	endfunction

	// stimulus, reset and end of run
	initial begin
		int kind;
		int len;
		clear_parse();

		// directed: empty, lone zero, minus zero, lone minus, plus, nul byte
		str_buf.delete();
		send_string(1'b0, 1'b0);
		load_text("0");
		send_string(1'b0, 1'b0);
		load_text("-0");
		send_string(1'b0, 1'b0);
		load_text("-");
		send_string(1'b0, 1'b0);
		load_text("+1");
		send_string(1'b0, 1'b0);
		str_buf.delete();
		str_buf.push_back(CHAR_NUL);
		send_string(1'b0, 1'b0);
		// digit, ignored transaction, then a bare end
		push_item(cdi32_pkg::CHAR_NINE, 1'b1, 1'b0);
		push_item(8'hA5, 1'b0, 1'b0);
		push_item(CHAR_NUL, 1'b0, 1'b1);
		load_text("--1");
		send_string(1'b0, 1'b0);
		str_buf.delete();
		str_buf.push_back(CHAR_HIGH);
		send_string(1'b0, 1'b0);
		load_text("05");
		send_string(1'b0, 1'b0);
		load_text(" 1");
		send_string(1'b0, 1'b0);

		// random strings, mostly well formed
		while (pending_chars.size() < ITEM_TARGET) begin
			if (!drain_placed && pending_chars.size() >= DRAIN_AT) begin
				drain_mark = 1'b1;
				drain_placed = 1'b1;
			end
			kind = $urandom_range(0, 19);
			if (kind < 13) begin
				load_number();
			end else if (kind < 17) begin
				load_number();
				mutate();
			end else begin
				str_buf.delete();
				len = $urandom_range(0, 12);
				for (int k = 0; k < len; k++)
					str_buf.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : noise_byte());
			end
			send_string($urandom_range(0, 4) == 0, 1'b1);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait at the rising edge, where the driven signals are settled
		while (pending_chars.size() != 0 || char_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// timeout
	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

	// driver: bursts of transactions with random gaps, one pause to drain
	always @(negedge clk) begin
		logic                next_valid;
		cdi32_pkg::in_item_t next_data;
		next_valid = char_valid;
		next_data = char_data;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (!char_valid || char_taken) begin
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_chars.size() != 0 &&
					!(pending_drain[0] && expected_results.size() != 0)) begin
				next_data = pending_chars.pop_front();
				void'(pending_drain.pop_front());
				next_valid = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		char_taken = 1'b0;
		char_valid <= next_valid;
		char_data <= next_data;
	end

	// result ready: rotating stall patterns plus one long hold-off
	always @(negedge clk) begin
		logic next_ready;
		if (!arst_n)
			next_ready = 1'b0;
		else if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
			next_ready = 1'b0;
		else begin
			case ((rx_cycle / 97) % 4)
				0: next_ready = 1'b1;
				1: next_ready = 1'($urandom_range(0, 1));
				2: next_ready = ($urandom_range(0, 3) == 0);
				default: next_ready = rx_cycle[2];
			endcase
		end
		if (arst_n)
			rx_cycle++;
		res_ready <= next_ready;
	end

	// monitor: predict on accepted input, compare accepted results
	always @(posedge clk) begin
		cdi32_pkg::out_item_t want;
		if (arst_n && char_valid && char_ready) begin
			predict_item(char_data);
			char_taken = 1'b1;
		end
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result is_valid=%0b parsed_value=%0d",
					$time, res_data.is_valid, res_data.parsed_value);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (res_data.is_valid !== want.is_valid) begin
					$display("%0t: is_valid expected %0b actual %0b",
						$time, want.is_valid, res_data.is_valid);
					fail_count++;
				end
				if (res_data.parsed_value !== want.parsed_value) begin
					$display("%0t: parsed_value expected %0d actual %0d",
						$time, want.parsed_value, res_data.parsed_value);
					fail_count++;
				end
			end
		end
	end

endmodule
